FILE: sv/box_blur_line_rgb_assert.svh
// Assertion macros for the box blur line filter.
// Taken in by the modules that carry concurrent checks; no other dependencies.
`ifndef BOX_BLUR_LINE_RGB_ASSERT_SVH
`define BOX_BLUR_LINE_RGB_ASSERT_SVH
`ifndef SYNTHESIS
// check out of reset
`define BBL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// check the cycle after reset is applied
`define BBL_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) (!(rstn)) |=> (prop)) else $error(msg);
`else
`define BBL_ASSERT(lbl, clk, rstn, prop, msg)
`define BBL_ASSERT_RST(lbl, clk, rstn, prop, msg)
`endif
`endif

FILE: sv/bbl_pkg.sv
// Shared constants and types for the box blur line filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bbl_pkg;

    localparam int PIX_W       = 8;
    localparam int CH_N        = 3;
    localparam int RAD_W       = 5;
    localparam int MAX_RADIUS  = 31;
    localparam int MAX_LINE    = 4096;

    localparam int STORE_DEPTH = 2 * MAX_RADIUS + 2;
    localparam int SLOT_W      = $clog2(STORE_DEPTH);
    localparam int POS_W       = $clog2(MAX_LINE);
    localparam int CNT_W       = $clog2(2 * MAX_RADIUS + 2);
    localparam int SUM_W       = PIX_W + $clog2(STORE_DEPTH);
    localparam int ARITH_W     = (POS_W > RAD_W + 1) ? POS_W + 1 : RAD_W + 2;

    localparam int QUO_W       = PIX_W;
    localparam int DIV_CELLS   = QUO_W;

    localparam int OFIFO_DEPTH = 16;
    localparam int OFIFO_PTR_W = $clog2(OFIFO_DEPTH);
    localparam int OFIFO_LVL_W = $clog2(OFIFO_DEPTH + 1);

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // register word indexes
    localparam logic [APB_ADDR_W-3:0] REG_IDX_RADIUS = '0;
    localparam logic [RAD_W-1:0]      RADIUS_RESET   = RAD_W'(1);

    // one division in flight: divisor shifted to the current quotient bit,
    // partial remainders and quotients of the three channels
    typedef struct packed {
        logic                            valid;
        logic                            done;
        logic [SUM_W-1:0]                dvs;
        logic [CH_N-1:0][SUM_W-1:0]      rem;
        logic [CH_N-1:0][QUO_W-1:0]      quo;
    } div_lane_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             done;
    } pix_out_t;

endpackage

FILE: sv/box_blur_line_rgb.sv
// Top level of the box blur line filter: window store, running sums,
// flush sequencer, divider chain and result queue.
// Depends on bbl_pkg, bbl_div_cell, bbl_out_fifo and the assertion header.
`timescale 1ns / 1ps
`include "box_blur_line_rgb_assert.svh"

// One-dimensional box filter over a line of RGB pixels (rows, or columns for
// the vertical pass). Pixels come in one per transfer on s_*, the final pixel
// of a line flagged by s_last_in_line; a pixel at position MAX_LINE-1 ends the
// line regardless. Each output is floor(window sum / window count) per
// channel, the window being position +/- radius clipped to the line ends.
// An output leaves once its window is complete, so results trail the input by
// radius pixels; the last pixel flushes the rest and m_line_done marks the
// final result of the line.
// Rate: one pixel per clock while a line streams and credits remain. The last
// pixel of a line is followed by a flush of the min(n, radius) results still
// pending (n = its position), one per step, during which s_ready is low; this is
// set by the single read port of the window store, one pixel dropped per step.
// A pixel transfer reaches the result it completes through the store read
// register, the sum update register, eight divider cells (one per quotient bit)
// and the result queue. The queue holds 16 results and a credit count keeps the
// pipeline from issuing more than it has room for, so a stalled m_ready stops
// intake only once 16 results are owed.
// The radius register (offset 0) is sampled at the first pixel of a line; a
// write mid-line takes effect on the next line. Radius 0 passes pixels through.
// The window store is not cleared after reset: every read hits a pixel written
// earlier in the same line, so it needs no clearing pass.
module box_blur_line_rgb import bbl_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // pixel input
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PIX_W-1:0]      s_red_in,
    input  logic [PIX_W-1:0]      s_green_in,
    input  logic [PIX_W-1:0]      s_blue_in,
    input  logic                  s_last_in_line,
    // result output
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PIX_W-1:0]      m_red_out,
    output logic [PIX_W-1:0]      m_green_out,
    output logic [PIX_W-1:0]      m_blue_out,
    output logic                  m_line_done
);

    typedef enum logic [1:0] {
        ST_RUN   = 2'b01,
        ST_FLUSH = 2'b10
    } seq_state_t;

    // one step of the sum pipeline: add a pixel, drop one, emit an average
    typedef struct packed {
        logic                       valid;
        logic                       first;
        logic                       add;
        logic                       drop;
        logic                       emit;
        logic                       done;
        logic [CNT_W-1:0]           count;
        logic [CH_N-1:0][PIX_W-1:0] px;
    } op_t;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [RAD_W-1:0] radius_reg;
    logic             cfg_wr;
    logic             cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[APB_ADDR_W-1:2] == REG_IDX_RADIUS);
    assign cfg_wr  = psel && penable && pwrite && cfg_hit;
    assign prdata  = cfg_hit ? APB_DATA_W'(radius_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RESET;
        end else if (cfg_wr) begin
            radius_reg <= pwdata[RAD_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Front end: line position, flush sequencer, store addressing
    // ------------------------------------------------------------------
    seq_state_t              state_reg, state_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [SLOT_W-1:0]       wr_slot_reg, wr_slot_next;
    logic [RAD_W-1:0]        active_r_reg, active_r_next;
    logic [POS_W-1:0]        fl_q_reg, fl_q_next;
    logic [POS_W-1:0]        fl_n_reg, fl_n_next;
    logic [SLOT_W-1:0]       fl_slot_reg, fl_slot_next;
    logic [OFIFO_LVL_W-1:0]  credit_reg, credit_next;

    logic                    s_xfer;
    logic                    m_xfer;
    logic                    fl_go;
    logic                    is_first;
    logic                    last_eff;
    logic [RAD_W-1:0]        rad_sat;
    logic [RAD_W-1:0]        r_cur;
    logic [ARITH_W-1:0]      n_a, r_a, two_r_a, q0_a;
    logic                    drop_run, emit_run, done_run;
    logic [CNT_W-1:0]        count_run;
    logic [SLOT_W:0]         span, slot_diff;
    logic [SLOT_W-1:0]       drop_slot;
    logic [SLOT_W-1:0]       rd_slot;
    logic [ARITH_W-1:0]      fq_a, fn_a, fr_a, fl_low;
    logic                    drop_fl, done_fl;
    logic [CNT_W-1:0]        count_fl;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(STORE_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    assign fl_go    = (state_reg == ST_FLUSH) && (credit_reg != '0);
    assign s_ready  = (state_reg == ST_RUN) && (credit_reg != '0);
    assign s_xfer   = s_valid && s_ready;
    assign is_first = (pos_reg == '0);
    assign last_eff = s_last_in_line || (pos_reg == POS_W'(MAX_LINE - 1));
    assign rad_sat  = (32'(radius_reg) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : radius_reg;

    // streaming step at position n: the result for position n - radius
    always_comb begin
        r_cur     = is_first ? rad_sat : active_r_reg;
        n_a       = ARITH_W'(pos_reg);
        r_a       = ARITH_W'(r_cur);
        two_r_a   = r_a << 1;
        drop_run  = (n_a > two_r_a);
        q0_a      = (n_a >= r_a) ? n_a - r_a : '0;
        // clipped window size: min(n, 2r) + 1
        count_run = CNT_W'(((n_a >= two_r_a) ? two_r_a : n_a) + ARITH_W'(1));
        emit_run  = last_eff || (n_a >= r_a);
        done_run  = last_eff && (q0_a == n_a);
        // slot of the pixel leaving the window, n - 2r - 1 modulo the depth
        span      = ((SLOT_W + 1)'(r_cur) << 1) + (SLOT_W + 1)'(1);
        slot_diff = {1'b0, wr_slot_reg} - span;
        drop_slot = slot_diff[SLOT_W] ? SLOT_W'(slot_diff + (SLOT_W + 1)'(STORE_DEPTH))
                                      : slot_diff[SLOT_W-1:0];
    end

    // flush step for pending position q of a line ending at n
    always_comb begin
        fq_a     = ARITH_W'(fl_q_reg);
        fn_a     = ARITH_W'(fl_n_reg);
        fr_a     = ARITH_W'(active_r_reg);
        fl_low   = (fq_a >= fr_a) ? fq_a - fr_a : '0;
        count_fl = CNT_W'(fn_a - fl_low + ARITH_W'(1));
        drop_fl  = (fq_a > fr_a);
        done_fl  = (fl_q_reg == fl_n_reg);
    end

    assign rd_slot = (state_reg == ST_FLUSH) ? fl_slot_reg : drop_slot;

    always_comb begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        wr_slot_next  = wr_slot_reg;
        active_r_next = active_r_reg;
        fl_q_next     = fl_q_reg;
        fl_n_next     = fl_n_reg;
        fl_slot_next  = fl_slot_reg;
        case (state_reg)
            ST_RUN: begin
                if (s_xfer) begin
                    if (is_first) begin
                        active_r_next = rad_sat;
                    end
                    if (last_eff) begin
                        pos_next     = '0;
                        wr_slot_next = '0;
                        if (!done_run) begin
                            state_next   = ST_FLUSH;
                            fl_q_next    = POS_W'(q0_a + ARITH_W'(1));
                            fl_n_next    = pos_reg;
                            fl_slot_next = slot_inc(drop_slot);
                        end
                    end else begin
                        pos_next     = pos_reg + 1'b1;
                        wr_slot_next = slot_inc(wr_slot_reg);
                    end
                end
            end
            ST_FLUSH: begin
                if (fl_go) begin
                    fl_q_next    = fl_q_reg + 1'b1;
                    fl_slot_next = slot_inc(fl_slot_reg);
                    if (done_fl) begin
                        state_next = ST_RUN;
                    end
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_RUN;
            pos_reg      <= '0;
            wr_slot_reg  <= '0;
            active_r_reg <= '0;
        end else begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            wr_slot_reg  <= wr_slot_next;
            active_r_reg <= active_r_next;
        end
    end

    always_ff @(posedge aclk) begin
        fl_q_reg    <= fl_q_next;
        fl_n_reg    <= fl_n_next;
        fl_slot_reg <= fl_slot_next;
    end

    // ------------------------------------------------------------------
    // Window store: written with each pixel, read for the leaving pixel
    // ------------------------------------------------------------------
    logic [CH_N-1:0][PIX_W-1:0] store_mem [STORE_DEPTH];
    logic [CH_N-1:0][PIX_W-1:0] rd_data_reg;
    logic [CH_N-1:0][PIX_W-1:0] px_in;

    assign px_in[0] = s_red_in;
    assign px_in[1] = s_green_in;
    assign px_in[2] = s_blue_in;

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            store_mem[wr_slot_reg] <= px_in;
        end
        rd_data_reg <= store_mem[rd_slot];
    end

    // ------------------------------------------------------------------
    // Step register and running sums
    // ------------------------------------------------------------------
    op_t op_reg, op_next;

    always_comb begin
        op_next.valid = s_xfer || fl_go;
        op_next.first = s_xfer && is_first;
        op_next.add   = s_xfer;
        op_next.drop  = s_xfer ? drop_run  : drop_fl;
        op_next.emit  = s_xfer ? emit_run  : 1'b1;
        op_next.done  = s_xfer ? done_run  : done_fl;
        op_next.count = s_xfer ? count_run : count_fl;
        op_next.px    = px_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg.valid <= 1'b0;
        end else begin
            op_reg <= op_next;
        end
    end

    logic [CH_N-1:0][SUM_W-1:0] sum_reg, sum_next;
    div_lane_t                  lane0_reg, lane0_next;

    always_comb begin
        for (int c = 0; c < CH_N; c++) begin
            sum_next[c] = (op_reg.first ? '0 : sum_reg[c])
                        + (op_reg.add  ? SUM_W'(op_reg.px[c])      : '0)
                        - (op_reg.drop ? SUM_W'(rd_data_reg[c])    : '0);
        end
        lane0_next.valid = op_reg.valid && op_reg.emit;
        lane0_next.done  = op_reg.done;
        lane0_next.dvs   = SUM_W'(op_reg.count) << (QUO_W - 1);
        lane0_next.rem   = sum_next;
        lane0_next.quo   = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (op_reg.valid) begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane0_reg.valid <= 1'b0;
        end else begin
            lane0_reg <= lane0_next;
        end
    end

    // ------------------------------------------------------------------
    // Divider chain, one cell per quotient bit
    // ------------------------------------------------------------------
    div_lane_t lanes [DIV_CELLS + 1];

    assign lanes[0] = lane0_reg;

    for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cells
        bbl_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .lane_in  (lanes[i]),
            .lane_out (lanes[i + 1])
        );
    end

    // ------------------------------------------------------------------
    // Result queue and credits
    // ------------------------------------------------------------------
    pix_out_t               fifo_in;
    pix_out_t               fifo_out;
    logic [OFIFO_LVL_W-1:0] fifo_level;

    assign fifo_in.red   = lanes[DIV_CELLS].quo[0];
    assign fifo_in.green = lanes[DIV_CELLS].quo[1];
    assign fifo_in.blue  = lanes[DIV_CELLS].quo[2];
    assign fifo_in.done  = lanes[DIV_CELLS].done;

    bbl_out_fifo u_out_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (lanes[DIV_CELLS].valid),
        .wr_data  (fifo_in),
        .rd_en    (m_xfer),
        .rd_valid (m_valid),
        .rd_data  (fifo_out),
        .level    (fifo_level)
    );

    assign m_xfer      = m_valid && m_ready;
    assign m_red_out   = fifo_out.red;
    assign m_green_out = fifo_out.green;
    assign m_blue_out  = fifo_out.blue;
    assign m_line_done = fifo_out.done;

    // a credit is a queue slot not yet promised to a result in flight
    assign credit_next = credit_reg
                       - OFIFO_LVL_W'(op_next.valid && op_next.emit)
                       + OFIFO_LVL_W'(m_xfer);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credit_reg <= OFIFO_LVL_W'(OFIFO_DEPTH);
        end else begin
            credit_reg <= credit_next;
        end
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `BBL_ASSERT(a_credit_bound, aclk, aresetn,
        (32'(credit_reg) + 32'(fifo_level)) <= OFIFO_DEPTH,
        "credits and queued results exceed queue depth")
    `BBL_ASSERT(a_flush_range, aclk, aresetn,
        (state_reg == ST_FLUSH) |-> ((fl_q_reg <= fl_n_reg) && (fl_q_reg != '0)),
        "flush position outside the line")
    `BBL_ASSERT(a_count_range, aclk, aresetn,
        (op_reg.valid && op_reg.emit) |-> ((op_reg.count != '0)
            && (32'(op_reg.count) <= 2 * 32'(active_r_reg) + 1)),
        "window count out of range")
    `BBL_ASSERT(a_line_restart, aclk, aresetn,
        (s_valid && s_ready && s_last_in_line) |=> (pos_reg == '0),
        "line position not cleared after last pixel")
    `BBL_ASSERT_RST(a_reset_credit, aclk, aresetn,
        (credit_reg == OFIFO_LVL_W'(OFIFO_DEPTH)),
        "credits not restored by reset")

endmodule

FILE: sv/bbl_div_cell.sv
// One cell of the divider chain: resolves one quotient bit per channel.
// Depends on bbl_pkg (div_lane_t, widths).
`timescale 1ns / 1ps

module bbl_div_cell import bbl_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  div_lane_t lane_in,
    output div_lane_t lane_out
);

    div_lane_t lane_reg;
    div_lane_t lane_next;

    // restoring step: subtract when the shifted divisor fits
    always_comb begin
        lane_next     = lane_in;
        lane_next.dvs = lane_in.dvs >> 1;
        for (int c = 0; c < CH_N; c++) begin
            if (lane_in.rem[c] >= lane_in.dvs) begin
                lane_next.rem[c] = lane_in.rem[c] - lane_in.dvs;
                lane_next.quo[c] = {lane_in.quo[c][QUO_W-2:0], 1'b1};
            end else begin
                lane_next.quo[c] = {lane_in.quo[c][QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_reg.valid <= 1'b0;
        end else begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

FILE: sv/bbl_out_fifo.sv
// Result queue between the divider chain and the output channel.
// Depends on bbl_pkg (pix_out_t, queue depth).
`timescale 1ns / 1ps

module bbl_out_fifo import bbl_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   wr_en,
    input  pix_out_t               wr_data,
    input  logic                   rd_en,
    output logic                   rd_valid,
    output pix_out_t               rd_data,
    output logic [OFIFO_LVL_W-1:0] level
);

    pix_out_t                 fifo_reg [OFIFO_DEPTH];
    logic [OFIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OFIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OFIFO_LVL_W-1:0]   level_reg, level_next;

    function automatic logic [OFIFO_PTR_W-1:0] ptr_inc(input logic [OFIFO_PTR_W-1:0] p);
        return (p == OFIFO_PTR_W'(OFIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        wr_ptr_next = wr_en ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = rd_en ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        level_next  = level_reg + OFIFO_LVL_W'(wr_en) - OFIFO_LVL_W'(rd_en);
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            fifo_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    assign rd_valid = (level_reg != '0);
    assign rd_data  = fifo_reg[rd_ptr_reg];
    assign level    = level_reg;

endmodule

FILE: dv/box_blur_line_rgb_tb.sv
// Self-checking testbench for box_blur_line_rgb: streams lines of RGB pixels,
// predicts every clipped window average and checks each result transfer in order.
// Depends on bbl_pkg and the box_blur_line_rgb RTL; needs no other files.
`timescale 1ns / 1ps

module box_blur_line_rgb_tb import bbl_pkg::*;;

    localparam int CYCLE_LIMIT    = 1_000_000;
    // settling covers the pipeline registers plus a 16-deep result queue
    localparam int SETTLE_CYCLES  = 40;
    localparam int IDLE_MAX       = 17;
    localparam int RAND_CHUNKS    = 6;
    localparam int CHUNK_PIXELS   = 30;
    localparam logic [APB_ADDR_W-1:0] RADIUS_ADDR = {REG_IDX_RADIUS, 2'b00};

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             last;
    } pix_in_t;

    // clock, reset and block ports; inputs start at known values
    logic                  aclk           = 1'b0;
    logic                  aresetn        = 1'b0;
    logic                  psel           = 1'b0;
    logic                  penable        = 1'b0;
    logic                  pwrite         = 1'b0;
    logic [APB_ADDR_W-1:0] paddr          = '0;
    logic [APB_DATA_W-1:0] pwdata         = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic [PIX_W-1:0]      s_red_in       = '0;
    logic [PIX_W-1:0]      s_green_in     = '0;
    logic [PIX_W-1:0]      s_blue_in      = '0;
    logic                  s_last_in_line = 1'b0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic [PIX_W-1:0]      m_red_out;
    logic [PIX_W-1:0]      m_green_out;
    logic [PIX_W-1:0]      m_blue_out;
    logic                  m_line_done;

    box_blur_line_rgb DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_red_in       (s_red_in),
        .s_green_in     (s_green_in),
        .s_blue_in      (s_blue_in),
        .s_last_in_line (s_last_in_line),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_red_out      (m_red_out),
        .m_green_out    (m_green_out),
        .m_blue_out     (m_blue_out),
        .m_line_done    (m_line_done)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state: window store, running sums, line position, radius
    logic [3*PIX_W-1:0] win_mem [STORE_DEPTH];
    logic [SUM_W-1:0]   sum_red     = '0;
    logic [SUM_W-1:0]   sum_green   = '0;
    logic [SUM_W-1:0]   sum_blue    = '0;
    logic [12:0]        line_pos    = '0;
    logic [RAD_W-1:0]   cfg_radius  = RADIUS_RESET;
    logic [RAD_W-1:0]   line_radius = '0;

    pix_in_t     pixel_feed [$];
    pix_out_t    pending_avgs [$];

    pix_in_t     src_cur;
    int unsigned src_wait;
    bit          src_busy;
    int unsigned sink_wait;
    bit          idle_calm;
    int unsigned run_left;

    int unsigned miss_count;
    int unsigned pixels_sent;
    int unsigned results_seen;
    int unsigned lines_seen;
    int unsigned radius_writes;

    task automatic flag_miss(input string what);
        miss_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [PIX_W-1:0] got,
                               input logic [PIX_W-1:0] want);
        if (got !== want) begin
            flag_miss($sformatf("result %0d %s: got %0h, expected %0h",
                                results_seen, name, got, want));
        end
    endtask

    function automatic int unsigned idle_draw();
        return idle_calm ? 0 : $urandom_range(0, IDLE_MAX);
    endfunction

    // mostly random content, with full-scale values now and then
    function automatic logic [PIX_W-1:0] chan_draw();
        if ($urandom_range(0, 7) == 0) begin
            return $urandom_range(0, 1) ? 8'hff : 8'h00;
        end
        return PIX_W'($urandom);
    endfunction

    // short lines dominate; some single pixels and a few long ones
    function automatic int unsigned line_len_draw();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return $urandom_range(1, 3);
        end else if (pick == 9) begin
            return $urandom_range(49, 120);
        end
        return $urandom_range(1, 48);
    endfunction

    task automatic drop_pixel(input int unsigned p);
        logic [3*PIX_W-1:0] w;
        w = win_mem[p % STORE_DEPTH];
        sum_red   -= w[23:16];
        sum_green -= w[15:8];
        sum_blue  -= w[7:0];
    endtask

    task automatic push_average(input int unsigned cnt, input bit done);
        pix_out_t avg;
        if (cnt == 0) begin
            cnt = 1;
        end
        avg.red   = PIX_W'(sum_red / cnt);
        avg.green = PIX_W'(sum_green / cnt);
        avg.blue  = PIX_W'(sum_blue / cnt);
        avg.done  = done;
        pending_avgs.push_back(avg);
    endtask

    // one accepted pixel: update the window and queue the averages it completes
    task automatic box_average_step(input pix_in_t px);
        int unsigned n, r, q, lo, first;
        bit          last;
        n    = line_pos;
        last = px.last;
        if (n == 0) begin
            // radius is latched at the first pixel of a line
            line_radius = (cfg_radius > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : cfg_radius;
            sum_red   = '0;
            sum_green = '0;
            sum_blue  = '0;
        end
        r = line_radius;
        // a line that reaches MAX_LINE pixels is closed at its last slot
        if (n >= MAX_LINE - 1) begin
            last = 1'b1;
        end
        if (n >= 2 * r + 1) begin
            drop_pixel(n - 2 * r - 1);
        end
        win_mem[n % STORE_DEPTH] = {px.red, px.green, px.blue};
        sum_red   += px.red;
        sum_green += px.green;
        sum_blue  += px.blue;
        if (!last) begin
            if (n >= r) begin
                q  = n - r;
                lo = (q >= r) ? q - r : 0;
                push_average(n - lo + 1, 1'b0);
            end
            line_pos = 13'(n + 1);
        end else begin
            // end of line: flush every position still owed
            first = (n >= r) ? n - r : 0;
            for (q = first; q <= n; q++) begin
                if (q > first && q >= r + 1) begin
                    drop_pixel(q - r - 1);
                end
                lo = (q >= r) ? q - r : 0;
                push_average(n - lo + 1, q == n);
            end
            sum_red   = '0;
            sum_green = '0;
            sum_blue  = '0;
            line_pos  = '0;
            lines_seen++;
        end
    endtask

    // pixel driver: one transfer per item, random gap before each
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_busy = 1'b0;
            src_wait = idle_draw();
        end else begin
            if (s_valid && s_ready) begin
                box_average_step(src_cur);
                pixels_sent++;
                src_busy = 1'b0;
                src_wait = idle_draw();
            end
            if (!src_busy) begin
                if (src_wait != 0) begin
                    src_wait--;
                    s_valid <= 1'b0;
                end else if (pixel_feed.size() != 0) begin
                    src_cur = pixel_feed.pop_front();
                    src_busy = 1'b1;
                    s_valid        <= 1'b1;
                    s_red_in       <= src_cur.red;
                    s_green_in     <= src_cur.green;
                    s_blue_in      <= src_cur.blue;
                    s_last_in_line <= src_cur.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: back-pressure counted against a waiting result
    always @(posedge aclk) begin
        pix_out_t got, want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_wait = idle_draw();
        end else begin
            if (m_valid && m_ready) begin
                got.red   = m_red_out;
                got.green = m_green_out;
                got.blue  = m_blue_out;
                got.done  = m_line_done;
                results_seen++;
                if (pending_avgs.size() == 0) begin
                    flag_miss($sformatf("result %0d arrived with nothing expected",
                                        results_seen));
                end else begin
                    want = pending_avgs.pop_front();
                    check_field("red", got.red, want.red);
                    check_field("green", got.green, want.green);
                    check_field("blue", got.blue, want.blue);
                    check_field("line_done", PIX_W'(got.done), PIX_W'(want.done));
                end
                sink_wait = idle_draw();
            end else if (m_valid && sink_wait != 0) begin
                sink_wait--;
            end
            m_ready <= (sink_wait == 0);
        end
    end

    task automatic apb_access(input bit wr, input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= RADIUS_ADDR;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // sender holds off until every owed result is in, then the pipe settles
    task automatic wait_drained();
        while (pixel_feed.size() != 0 || src_busy || pending_avgs.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic check_radius_reg(input logic [RAD_W-1:0] want);
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b0, '0, rd);
        if (rd !== APB_DATA_W'(want)) begin
            flag_miss($sformatf("radius readback: got %0h, expected %0h", rd, want));
        end
    endtask

    task automatic set_radius(input logic [RAD_W-1:0] val);
        logic [APB_DATA_W-1:0] rd;
        wait_drained();
        apb_access(1'b1, APB_DATA_W'(val), rd);
        cfg_radius = val;
        radius_writes++;
        check_radius_reg(val);
    endtask

    task automatic push_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] b, input bit last);
        pix_in_t px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        px.last  = last;
        pixel_feed.push_back(px);
    endtask

    // random lines; a line may run on past a chunk into the next radius setting
    task automatic feed_pixels(input int unsigned count);
        repeat (count) begin
            if (run_left == 0) begin
                run_left = line_len_draw();
            end
            push_pixel(chan_draw(), chan_draw(), chan_draw(), run_left == 1);
            run_left--;
        end
    endtask

    initial begin : watchdog
        int unsigned cyc;
        cyc = 0;
        while (cyc < CYCLE_LIMIT) begin
            @(posedge aclk);
            cyc++;
        end
        $display("timeout after %0d cycles", cyc);
        $display("box_blur_line_rgb_tb: FAIL");
        $finish;
    end

    initial begin : stimulus
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        check_radius_reg(RADIUS_RESET);

        // reset radius: full-scale channels, then a one-pixel line
        push_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        push_pixel(8'hff, 8'hff, 8'hff, 1'b0);
        push_pixel(8'h55, 8'haa, 8'h0f, 1'b1);
        push_pixel(8'hff, 8'h00, 8'hff, 1'b1);

        // radius zero passes pixels straight through
        set_radius('0);
        push_pixel(8'h12, 8'h34, 8'h56, 1'b0);
        push_pixel(8'hab, 8'hcd, 8'hef, 1'b1);

        // widest window over a line much shorter than it
        set_radius(RAD_W'(MAX_RADIUS));
        push_pixel(8'hff, 8'hff, 8'hff, 1'b0);
        push_pixel(8'hff, 8'hff, 8'hff, 1'b0);
        push_pixel(8'h00, 8'h80, 8'h01, 1'b0);
        push_pixel(8'hfe, 8'h01, 8'h7f, 1'b1);

        // radius rewritten mid-line only applies to the following line
        set_radius(RAD_W'(2));
        push_pixel(8'd10, 8'd20, 8'd30, 1'b0);
        push_pixel(8'd200, 8'd100, 8'd50, 1'b0);
        push_pixel(8'hff, 8'h00, 8'hff, 1'b0);
        set_radius(RAD_W'(5));
        push_pixel(8'd1, 8'd2, 8'd3, 1'b0);
        push_pixel(8'd250, 8'd251, 8'd252, 1'b0);
        push_pixel(8'd7, 8'd8, 8'd9, 1'b1);
        push_pixel(8'd90, 8'd180, 8'd45, 1'b0);
        push_pixel(8'd45, 8'd90, 8'd180, 1'b1);

        // random lines under a spread of radii, one chunk without idling
        run_left = 0;
        for (int ph = 0; ph < RAND_CHUNKS; ph++) begin
            if (ph == 0) begin
                set_radius(RAD_W'(MAX_RADIUS));
            end else if (ph == 1) begin
                set_radius('0);
            end else begin
                set_radius(RAD_W'($urandom_range(0, MAX_RADIUS)));
            end
            idle_calm = (ph == 3);
            feed_pixels(CHUNK_PIXELS);
        end

        // close the line left open by the last chunk
        if (run_left != 0) begin
            run_left = 1;
            feed_pixels(1);
        end
        wait_drained();

        if (pending_avgs.size() != 0) begin
            flag_miss($sformatf("%0d expected results never arrived", pending_avgs.size()));
        end
        $display("Run covered %0d pixels in %0d lines, %0d results, %0d radius writes,",
                 pixels_sent, lines_seen, results_seen, radius_writes);
        $display("radius 0 to %0d, a mid-line radius change, one-pixel lines and stalls",
                 MAX_RADIUS);
        if (miss_count == 0) begin
            $display("box_blur_line_rgb_tb: PASS");
        end else begin
            $display("box_blur_line_rgb_tb: FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/bbl_pkg.sv
sv/bbl_div_cell.sv
sv/bbl_out_fifo.sv
sv/box_blur_line_rgb.sv
dv/box_blur_line_rgb_tb.sv
